### rtl/zelr_pkg.sv
`timescale 1ns / 1ps
package zelr_pkg;

	localparam int GridW = 16;
	localparam int DtW   = 24;
	localparam int PctW  = 7;
	localparam int MagW  = 17;
	localparam int DvdW  = 48;
	localparam int DvsW  = 26;
	localparam int StepW = 26;
	localparam int FracW = 16;
	localparam int CfgW  = 16;

	localparam logic [PctW-1:0] FullPct = 7'd100;

	typedef enum logic [2:0] {
		REG_ENABLE    = 3'd0,
		REG_MAX_GRID  = 3'd1,
		REG_MINIMUM   = 3'd2,
		REG_HYST      = 3'd3,
		REG_RESET_T   = 3'd4,
		REG_TOTAL_PWR = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic                    enable;
		logic signed [GridW-1:0] max_grid_w;
		logic [PctW-1:0]         minimum_pct;
		logic [PctW-1:0]         hysteresis_pct;
		logic [15:0]             reset_time_s;
		logic [15:0]             total_max_power_w;
	} cfg_t;

	// one queued word: enable, sign and magnitude of the corrected reading, and elapsed time
	typedef struct packed {
		logic            enable;
		logic            neg;
		logic [MagW-1:0] smag;
		logic [DtW-1:0]  dt;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/zero_export_limit_regulator_core.sv
`timescale 1ns / 1ps
// channel  dir  handshake              word
// in       in   in_valid / in_ready    grid_power_w, elapsed_ms
// out      out  out_valid / out_ready  limit_pct, committed
// cfg      in   cfg_we                 cfg_index, cfg_wdata
//
// Enabled word: queue pop to output register runs one 48-step shared divider
// for the proportional term and, unless that saturates, again for the integral
// increment, plus multiply, reload and finish steps; before the pop it passes
// the front register and the queue. Disabled word: pop goes straight to finish.
// Reset clears the configuration to defaults and both held limits to zero.
// A two-entry queue lets input keep flowing while the back end or out stalls.
module zero_export_limit_regulator_core import zelr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [GridW-1:0] grid_power_w,
	input  logic [DtW-1:0]          elapsed_ms,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PctW-1:0]         limit_pct,
	output logic                    committed,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [CfgW-1:0]         cfg_wdata
);

	cfg_t    cfg_q;
	logic    push_valid;
	logic    push_ready;
	job_t    push_job;
	logic    pop_valid;
	logic    pop_ready;
	job_t    pop_job;
	q_stat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= 1'b0;
			cfg_q.max_grid_w        <= '0;
			cfg_q.minimum_pct       <= 7'd10;
			cfg_q.hysteresis_pct    <= '0;
			cfg_q.reset_time_s      <= 16'd1;
			cfg_q.total_max_power_w <= 16'd1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE:    cfg_q.enable            <= cfg_wdata[0];
				REG_MAX_GRID:  cfg_q.max_grid_w        <= cfg_wdata;
				REG_MINIMUM:   cfg_q.minimum_pct       <= cfg_wdata[PctW-1:0];
				REG_HYST:      cfg_q.hysteresis_pct    <= cfg_wdata[PctW-1:0];
				REG_RESET_T:   cfg_q.reset_time_s      <= cfg_wdata;
				REG_TOTAL_PWR: cfg_q.total_max_power_w <= cfg_wdata;
				default: ;
			endcase
		end
	end

	zelr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.grid_power_w (grid_power_w),
		.elapsed_ms   (elapsed_ms),
		.cfg          (cfg_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_job     (push_job)
	);

	zelr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job),
		.stat       (qstat)
	);

	zelr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.limit_pct (limit_pct),
		.committed (committed)
	);

	a_q_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue full and empty at once");

	a_limit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (limit_pct <= FullPct || limit_pct == cfg_q.minimum_pct))
		else $error("limit outside clamp range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full && !pop_ready |=> !push_ready)
		else $error("queue accepted a word while full");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(limit_pct))
		else $error("result dropped under stall");

endmodule

### rtl/zelr_front.sv
`timescale 1ns / 1ps
module zelr_front import zelr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [GridW-1:0] grid_power_w,
	input  logic [DtW-1:0]          elapsed_ms,
	input  cfg_t                    cfg,
	output logic                    push_valid,
	input  logic                    push_ready,
	output job_t                    push_job
);

	logic            v_s1;
	job_t            job_s1;
	job_t            job_d;
	logic signed [MagW-1:0] s;

	assign s = $signed({grid_power_w[GridW-1], grid_power_w})
		+ $signed({cfg.max_grid_w[GridW-1], cfg.max_grid_w});

	always_comb begin
		job_d.enable = cfg.enable;
		job_d.neg    = s[MagW-1];
		job_d.smag   = s[MagW-1] ? MagW'(-s) : MagW'(s);
		job_d.dt     = elapsed_ms;
	end

	assign in_ready   = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_job   = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_s1 <= job_d;
		end
	end

endmodule

### rtl/zelr_queue.sv
`timescale 1ns / 1ps
module zelr_queue import zelr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  job_t    push_job,
	output logic    pop_valid,
	input  logic    pop_ready,
	output job_t    pop_job,
	output q_stat_t stat
);

	job_t       mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;
	assign push_ready = !stat.full;
	assign pop_valid  = !stat.empty;
	assign pop_job    = mem[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_job;
		end
	end

endmodule

### rtl/zelr_div.sv
`timescale 1ns / 1ps
module zelr_div import zelr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DvdW-1:0] dividend,
	input  logic [DvsW-1:0] divisor,
	output logic            done,
	output logic [DvdW-1:0] quot
);

	localparam int CntW = $clog2(DvdW);

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [DvdW-1:0] dvd_q;
	logic [DvsW-1:0] rem_q;
	logic [DvsW-1:0] dvs_q;
	logic [DvsW:0]   t;
	logic [DvsW:0]   diff;
	logic            ge;

	// restoring division, one quotient bit per cycle
	assign t    = {rem_q, dvd_q[DvdW-1]};
	assign diff = t - {1'b0, dvs_q};
	assign ge   = t >= {1'b0, dvs_q};
	assign done = done_q;
	assign quot = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DvdW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DvsW-1:0] : t[DvsW-1:0];
			dvd_q <= {dvd_q[DvdW-2:0], ge};
		end
	end

endmodule

### rtl/zelr_back.sv
`timescale 1ns / 1ps
module zelr_back import zelr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            job_valid,
	output logic            job_ready,
	input  job_t            job,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [PctW-1:0] limit_pct,
	output logic            committed
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIVP,
		S_MUL,
		S_LOAD,
		S_DIVI,
		S_FIN
	} state_t;

	localparam int SumW = StepW + 2;
	localparam int RndW = SumW - FracW;

	state_t           state_q;
	logic             en_q;
	logic             neg_q;
	logic [DtW-1:0]   dt_q;
	logic [23:0]      pmag_q;
	logic [DvdW-1:0]  prod_q;
	logic [StepW-1:0] step_q;
	logic [PctW-1:0]  prev_q;
	logic [PctW-1:0]  comm_q;
	logic             out_valid_q;
	logic [PctW-1:0]  limit_q;
	logic             committed_q;

	logic             div_start;
	logic [DvdW-1:0]  div_dividend;
	logic [DvsW-1:0]  div_divisor;
	logic             div_done;
	logic [DvdW-1:0]  div_quot;
	logic [23:0]      p100;
	logic [DvsW-1:0]  tn1000;

	logic signed [SumW-1:0] base;
	logic signed [SumW-1:0] stepx;
	logic signed [SumW-1:0] sum;
	logic [SumW-1:0]        mag;
	logic [RndW-1:0]        rmag;
	logic signed [RndW:0]   r;
	logic [PctW-1:0]        reg_lim;
	logic [PctW-1:0]        lim_d;
	logic [PctW-1:0]        diff;
	logic                   cm_d;
	logic                   fin_go;

	assign p100   = 24'(job.smag) * 24'd100;
	assign tn1000 = (cfg.reset_time_s == 16'd0) ? DvsW'(1000)
		: DvsW'(cfg.reset_time_s) * DvsW'(1000);

	assign div_start    = (state_q == S_IDLE && job_valid && job.enable)
		|| state_q == S_LOAD;
	assign div_dividend = (state_q == S_IDLE) ? {8'd0, p100, 16'd0} : prod_q;
	assign div_divisor  = (state_q == S_IDLE)
		? ((cfg.total_max_power_w == 16'd0) ? DvsW'(1) : DvsW'(cfg.total_max_power_w))
		: tn1000;

	zelr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign job_ready = state_q == S_IDLE;

	// round half away from zero, then clamp, then check hysteresis against the committed limit
	always_comb begin
		base  = $signed({5'd0, prev_q, 16'd0});
		stepx = $signed({2'd0, step_q});
		sum   = neg_q ? base - stepx : base + stepx;
		mag   = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
		rmag  = RndW'((mag + SumW'(32768)) >> FracW);
		r     = sum[SumW-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
		if (r > $signed((RndW+1)'(FullPct))) begin
			reg_lim = FullPct;
		end else if (r < $signed((RndW+1)'(cfg.minimum_pct))) begin
			reg_lim = cfg.minimum_pct;
		end else begin
			reg_lim = r[PctW-1:0];
		end
		lim_d = en_q ? reg_lim : FullPct;
		diff  = (lim_d >= comm_q) ? lim_d - comm_q : comm_q - lim_d;
		cm_d  = diff >= cfg.hysteresis_pct;
	end

	assign fin_go    = state_q == S_FIN && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign limit_pct = limit_q;
	assign committed = committed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			en_q        <= 1'b0;
			neg_q       <= 1'b0;
			dt_q        <= '0;
			pmag_q      <= '0;
			prod_q      <= '0;
			step_q      <= '0;
			prev_q      <= '0;
			comm_q      <= '0;
			out_valid_q <= 1'b0;
			limit_q     <= '0;
			committed_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						en_q    <= job.enable;
						neg_q   <= job.neg;
						dt_q    <= job.dt;
						state_q <= job.enable ? S_DIVP : S_FIN;
					end
				end
				S_DIVP: begin
					if (div_done) begin
						// saturate: a step this large always clamps
						if (div_quot[DvdW-1:24] != '0) begin
							step_q  <= '1;
							state_q <= S_FIN;
						end else begin
							pmag_q  <= div_quot[23:0];
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					prod_q  <= DvdW'(pmag_q) * DvdW'(dt_q);
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIVI;
				end
				S_DIVI: begin
					if (div_done) begin
						if (div_quot[DvdW-1:25] != '0) step_q <= '1;
						else step_q <= StepW'(pmag_q) + StepW'(div_quot[24:0]);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						limit_q     <= lim_d;
						committed_q <= cm_d;
						if (cm_d) comm_q <= lim_d;
						if (en_q) prev_q <= lim_d;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### tb/sv/tb_zero_export_limit_regulator_core.sv
`timescale 1ns / 1ps
module tb_zero_export_limit_regulator_core;
	import zelr_pkg::*;

	typedef struct packed {
		logic signed [GridW-1:0] grid;
		logic [DtW-1:0]          dt;
	} reading_t;

	typedef struct packed {
		logic [PctW-1:0] limit;
		logic            commit;
	} limit_res_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [GridW-1:0] grid_power_w;
	logic [DtW-1:0]          elapsed_ms;
	logic                    out_valid;
	logic                    out_ready;
	logic [PctW-1:0]         limit_pct;
	logic                    committed;
	logic                    cfg_we;
	logic [2:0]              cfg_index;
	logic [CfgW-1:0]         cfg_wdata;

	zero_export_limit_regulator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.grid_power_w(grid_power_w), .elapsed_ms(elapsed_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.limit_pct(limit_pct), .committed(committed),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// predictor copy of the configuration and held limits
	logic                    m_enable;
	logic signed [GridW-1:0] m_max_grid;
	logic [PctW-1:0]         m_minimum;
	logic [PctW-1:0]         m_hyst;
	logic [15:0]             m_reset_t;
	logic [15:0]             m_total;
	logic [PctW-1:0]         m_prev_limit;
	logic [PctW-1:0]         m_comm_limit;

	reading_t   pending_words[$];
	limit_res_t expected_limits[$];
	int         errors;
	int         cycles;
	bit         drv_paused;

	always #5 clk = ~clk;

	function automatic logic [PctW-1:0] pi_limit(reading_t r);
		logic signed [31:0] s;
		logic               neg;
		logic [63:0]        smag, total, tn, pmag, imag, stp;
		logic signed [63:0] sum, rnd;
		s = 32'(r.grid) + 32'(m_max_grid);
		neg = s < 0;
		smag = neg ? 64'(-s) : 64'(s);
		total = (m_total == 0) ? 64'd1 : 64'(m_total);
		tn = (m_reset_t == 0) ? 64'd1 : 64'(m_reset_t);
		pmag = ((smag * 64'd100) << FracW) / total;
		imag = (pmag * 64'(r.dt)) / (64'd1000 * tn);
		stp = pmag + imag;
		sum = (64'(m_prev_limit) << FracW) + (neg ? -$signed(stp) : $signed(stp));
		if (sum >= 0)
			rnd = $signed((64'(sum) + 64'd32768) >> FracW);
		else
			rnd = -$signed((64'(-sum) + 64'd32768) >> FracW);
		if (rnd > 100)
			rnd = 100;
		else if (rnd < $signed(64'(m_minimum)))
			rnd = 64'(m_minimum);
		return rnd[PctW-1:0];
	endfunction

	function automatic limit_res_t next_limit(reading_t r);
		limit_res_t res;
		logic [PctW-1:0] diff;
		if (m_enable) begin
			res.limit = pi_limit(r);
			m_prev_limit = res.limit;
		end else begin
			res.limit = FullPct;
		end
		diff = (res.limit >= m_comm_limit) ? res.limit - m_comm_limit
		                                   : m_comm_limit - res.limit;
		res.commit = !(diff < m_hyst);
		if (res.commit)
			m_comm_limit = res.limit;
		return res;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [CfgW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_ENABLE:    m_enable = val[0];
		REG_MAX_GRID:  m_max_grid = val;
		REG_MINIMUM:   m_minimum = val[PctW-1:0];
		REG_HYST:      m_hyst = val[PctW-1:0];
		REG_RESET_T:   m_reset_t = val;
		REG_TOTAL_PWR: m_total = val;
		default: ;
		endcase
	endtask

	// hold until queue drained and nothing outstanding
	task automatic wait_idle();
		while (pending_words.size() != 0 || expected_limits.size() != 0 || in_valid)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic add_word(logic signed [GridW-1:0] g, logic [DtW-1:0] d);
		reading_t r;
		r.grid = g;
		r.dt = d;
		pending_words.push_back(r);
	endtask

	task automatic rand_cfg(bit extreme);
		write_reg(REG_ENABLE, CfgW'($urandom_range(0, 5) != 0));
		write_reg(REG_MAX_GRID, extreme ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
		                                 : CfgW'($urandom_range(0, 4000) - 2000));
		write_reg(REG_MINIMUM, extreme ? ($urandom_range(0, 1) ? 16'd127 : 16'd0)
		                                : CfgW'($urandom_range(0, 60)));
		write_reg(REG_HYST, extreme ? ($urandom_range(0, 1) ? 16'd127 : 16'd100)
		                             : CfgW'($urandom_range(0, 8)));
		write_reg(REG_RESET_T, extreme ? ($urandom_range(0, 1) ? 16'hffff : 16'd0)
		                                : CfgW'($urandom_range(1, 200)));
		write_reg(REG_TOTAL_PWR, extreme ? ($urandom_range(0, 1) ? 16'hffff : 16'd0)
		                                  : CfgW'($urandom_range(500, 65535)));
	endtask

	// acceptance seen at the last rising edge
	logic in_ready_seen;

	// driver: bursts and gaps
	int gap_left;
	int burst_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			grid_power_w <= '0;
			elapsed_ms <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (!in_valid || in_ready_seen) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0 && !drv_paused) begin
				reading_t r;
				r = pending_words.pop_front();
				in_valid <= 1'b1;
				grid_power_w <= r.grid;
				elapsed_ms <= r.dt;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 250);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ready_seen <= 1'b0;
		end else begin
			in_ready_seen <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				reading_t r;
				r.grid = grid_power_w;
				r.dt = elapsed_ms;
				expected_limits.push_back(next_limit(r));
			end
		end
	end

	// receiver stall pattern
	int stall_phase;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase[11:9] == 3'd0)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 3) != 0) && (stall_phase[4:2] != 3'd5);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_limits.size() == 0) begin
				$error("unexpected word: limit_pct %0d committed %0d", limit_pct, committed);
				errors++;
			end else begin
				limit_res_t e;
				e = expected_limits.pop_front();
				if (limit_pct !== e.limit) begin
					$error("limit_pct expected %0d actual %0d", e.limit, limit_pct);
					errors++;
				end
				if (committed !== e.commit) begin
					$error("committed expected %0d actual %0d", e.commit, committed);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 1500000) begin
			$display("tb_zero_export_limit_regulator_core: errors");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		errors = 0;
		cycles = 0;
		drv_paused = 1'b0;
		m_enable = 1'b0;
		m_max_grid = '0;
		m_minimum = 7'd10;
		m_hyst = '0;
		m_reset_t = 16'd1;
		m_total = 16'd1;
		m_prev_limit = '0;
		m_comm_limit = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: disabled, requests full limit
		add_word(16'sh7fff, 24'hffffff);
		add_word(16'sh8000, 24'h0);
		wait_idle();
		write_reg(REG_ENABLE, 16'd1);
		add_word(16'sh7fff, 24'hffffff);
		add_word(16'sh8000, 24'hffffff);
		add_word(16'sh0000, 24'h0);
		wait_idle();
		write_reg(REG_TOTAL_PWR, 16'd0);
		write_reg(REG_RESET_T, 16'd0);
		add_word(16'sh0001, 24'd1);
		add_word(-16'sd1, 24'd1);
		wait_idle();
		write_reg(REG_TOTAL_PWR, 16'hffff);
		write_reg(REG_RESET_T, 16'hffff);
		write_reg(REG_MAX_GRID, 16'h7fff);
		write_reg(REG_MINIMUM, 16'd120);
		add_word(16'sh8000, 24'd1000);
		add_word(16'sh7fff, 24'hffffff);
		add_word(16'sh0100, 24'h5a5a5a);
		wait_idle();
		write_reg(REG_MINIMUM, 16'd0);
		write_reg(REG_HYST, 16'd5);
		write_reg(REG_MAX_GRID, 16'h8000);
		add_word(16'sh0000, 24'd500);
		add_word(16'sh4000, 24'd300);
		add_word(16'sh1234, 24'ha5a5a5);
		add_word(-16'sd327, 24'd1000);
		wait_idle();
		write_reg(REG_ENABLE, 16'd0);
		write_reg(REG_HYST, 16'd100);
		add_word(16'sh0000, 24'd0);
		add_word(16'sh0000, 24'd0);
		wait_idle();

		for (int ph = 0; ph < 24; ph++) begin
			rand_cfg(ph % 5 == 0);
			for (int k = 0; k < 60; k++) begin
				logic signed [GridW-1:0] g;
				logic [DtW-1:0] d;
				g = ($urandom_range(0, 7) == 0) ? GridW'($urandom)
				                               : GridW'($urandom_range(0, 3000) - 1500);
				case ($urandom_range(0, 3))
				0: d = DtW'($urandom);
				1: d = 24'hffffff;
				default: d = DtW'($urandom_range(0, 3000));
				endcase
				add_word(g, d);
			end
			// phase 10 pauses the driver until accepted words are checked; all drains before the next phase
			if (ph == 10) begin
				drv_paused = 1'b1;
				while (expected_limits.size() != 0 || in_valid) @(negedge clk);
				drv_paused = 1'b0;
			end
			wait_idle();
		end

		while (expected_limits.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0 && expected_limits.size() == 0)
			$display("tb_zero_export_limit_regulator_core: clean");
		else
			$display("tb_zero_export_limit_regulator_core: errors");
		$finish;
	end

endmodule

### files.f
rtl/zelr_pkg.sv
rtl/zelr_front.sv
rtl/zelr_queue.sv
rtl/zelr_div.sv
rtl/zelr_back.sv
rtl/zero_export_limit_regulator_core.sv
tb/sv/tb_zero_export_limit_regulator_core.sv
